// File: design/spirv_decoration_remapper_unit_assert.svh
// Assertion macros shared by the remapper modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SPIRV_DECORATION_REMAPPER_UNIT_ASSERT_SVH
`define SPIRV_DECORATION_REMAPPER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sdr_pkg.sv
`default_nettype none

package sdr_pkg;

  // Table and header sizes
  localparam int unsigned TABLE_SLOTS  = 16;
  localparam int unsigned HEADER_WORDS = 5;

  // Queue between parser and rewrite stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QueuePtrW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QueueCntW   = $clog2(QUEUE_DEPTH + 1);

  // SPIR-V codes
  localparam logic [15:0] OpDecorate   = 16'd71;
  localparam logic [31:0] DecLocation  = 32'd30;
  localparam logic [31:0] DecBinding   = 32'd33;
  localparam logic [31:0] DecSet       = 32'd34;

  // Captured decoration kind (0 means not remappable)
  localparam logic [1:0] KindNone     = 2'd0;
  localparam logic [1:0] KindLocation = 2'd1;
  localparam logic [1:0] KindBinding  = 2'd2;
  localparam logic [1:0] KindSet      = 2'd3;

  // Request type
  localparam logic ReqSlotWrite = 1'b0;
  localparam logic ReqWord      = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] code_word;
    logic        module_start;
    logic [3:0]  slot_index;
    logic [31:0] slot_target_id;
    logic [1:0]  slot_kind;
    logic [7:0]  slot_new_value;
    logic        slot_enable;
  } sdr_in_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        was_replaced;
    logic        bad_length;
  } sdr_out_t;

  // Classified item passed from parser to rewrite stage
  typedef struct packed {
    logic        is_write;   // table slot write, no result
    logic [31:0] word;       // module word
    logic        bad;        // zero word count seen
    logic        lookup;     // search the table for this word
    logic [31:0] id;         // lookup id, or slot id on a write
    logic [1:0]  kind;       // table kind (0..3)
    logic [7:0]  value;      // slot value on a write
    logic [3:0]  idx;        // slot index on a write
    logic        enable;     // slot enable on a write
  } sdr_entry_t;

endpackage

`default_nettype wire

// File: design/sdr_front.sv
`default_nettype none

module sdr_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire sdr_pkg::sdr_in_t   in_req_i,
  output      logic               push_o,
  output      sdr_pkg::sdr_entry_t push_entry_o,
  input  wire logic               push_ready_i
);
  import sdr_pkg::*;

  logic [2:0]  header_left_q, header_left_d;
  logic [15:0] words_left_q, words_left_d;
  logic [1:0]  word_offset_q, word_offset_d;
  logic        in_decorate_q, in_decorate_d;
  logic        long_enough_q, long_enough_d;
  logic [31:0] captured_id_q, captured_id_d;
  logic [1:0]  captured_kind_q, captured_kind_d;

  logic        accept;
  logic [15:0] count;
  logic [2:0]  pos;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;
  assign count      = in_req_i.code_word[31:16];
  assign pos        = {1'b0, word_offset_q} + 3'd1;

  // Track header and instruction boundaries, classify the item
  always_comb begin
    header_left_d   = header_left_q;
    words_left_d    = words_left_q;
    word_offset_d   = word_offset_q;
    in_decorate_d   = in_decorate_q;
    long_enough_d   = long_enough_q;
    captured_id_d   = captured_id_q;
    captured_kind_d = captured_kind_q;

    push_entry_o.is_write = (in_req_i.req_type == ReqSlotWrite);
    push_entry_o.word     = in_req_i.code_word;
    push_entry_o.bad      = 1'b0;
    push_entry_o.lookup   = 1'b0;
    push_entry_o.id       = in_req_i.slot_target_id;
    push_entry_o.kind     = in_req_i.slot_kind;
    push_entry_o.value    = in_req_i.slot_new_value;
    push_entry_o.idx      = in_req_i.slot_index;
    push_entry_o.enable   = in_req_i.slot_enable;

    if (in_req_i.req_type == ReqWord) begin
      push_entry_o.id   = captured_id_q;
      push_entry_o.kind = captured_kind_q - 2'd1;
      if (in_req_i.module_start) begin
        header_left_d   = 3'(HEADER_WORDS - 1);
        words_left_d    = '0;
        word_offset_d   = '0;
        in_decorate_d   = 1'b0;
        long_enough_d   = 1'b0;
        captured_kind_d = KindNone;
      end else if (header_left_q != 3'd0) begin
        header_left_d = header_left_q - 3'd1;
      end else if (words_left_q == 16'd0) begin
        push_entry_o.bad = (count == 16'd0);
        words_left_d     = (count == 16'd0) ? 16'd0 : count - 16'd1;
        word_offset_d    = '0;
        in_decorate_d    = (in_req_i.code_word[15:0] == OpDecorate);
        long_enough_d    = (count >= 16'd4);
        captured_kind_d  = KindNone;
      end else begin
        words_left_d = words_left_q - 16'd1;
        if (word_offset_q != 2'd3) begin
          word_offset_d = pos[1:0];
        end
        if (in_decorate_q && pos <= 3'd3) begin
          case (pos)
            3'd1: captured_id_d = in_req_i.code_word;
            3'd2: begin
              if (in_req_i.code_word == DecLocation) begin
                captured_kind_d = KindLocation;
              end else if (in_req_i.code_word == DecBinding) begin
                captured_kind_d = KindBinding;
              end else if (in_req_i.code_word == DecSet) begin
                captured_kind_d = KindSet;
              end else begin
                captured_kind_d = KindNone;
              end
            end
            3'd3: push_entry_o.lookup = long_enough_q && (captured_kind_q != KindNone);
            default: ;
          endcase
        end
      end
    end
  end

  // Advance parser state on each word transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_left_q   <= '0;
      words_left_q    <= '0;
      word_offset_q   <= '0;
      in_decorate_q   <= 1'b0;
      long_enough_q   <= 1'b0;
      captured_id_q   <= '0;
      captured_kind_q <= KindNone;
    end else if (accept) begin
      header_left_q   <= header_left_d;
      words_left_q    <= words_left_d;
      word_offset_q   <= word_offset_d;
      in_decorate_q   <= in_decorate_d;
      long_enough_q   <= long_enough_d;
      captured_id_q   <= captured_id_d;
      captured_kind_q <= captured_kind_d;
    end
  end

endmodule

`default_nettype wire

// File: design/sdr_queue.sv
`default_nettype none

`include "spirv_decoration_remapper_unit_assert.svh"

module sdr_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire sdr_pkg::sdr_entry_t push_entry_i,
  output      logic                push_ready_o,
  output      logic                head_valid_o,
  output      sdr_pkg::sdr_entry_t head_o,
  input  wire logic                pop_i
);
  import sdr_pkg::*;

  sdr_entry_t               mem_q [QUEUE_DEPTH];
  logic [QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]     count_q;

  assign push_ready_o = (count_q < QueueCntW'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `SDR_ASSERT_NOW(a_no_push_full, push_i, count_q < QueueCntW'(QUEUE_DEPTH), "push into full queue")
  `SDR_ASSERT_NOW(a_no_pop_empty, pop_i, count_q != '0, "pop from empty queue")
  `SDR_ASSERT_NXT(a_count_hold, push_i && pop_i, count_q == $past(count_q), "count moved on push and pop")

endmodule

`default_nettype wire

// File: design/sdr_back.sv
`default_nettype none

`include "spirv_decoration_remapper_unit_assert.svh"

module sdr_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                head_valid_i,
  input  wire sdr_pkg::sdr_entry_t head_i,
  output      logic                pop_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      sdr_pkg::sdr_out_t   out_rsp_o
);
  import sdr_pkg::*;

  logic        slot_valid_q [TABLE_SLOTS];
  logic [31:0] slot_id_q    [TABLE_SLOTS];
  logic [1:0]  slot_type_q  [TABLE_SLOTS];
  logic [7:0]  slot_value_q [TABLE_SLOTS];

  logic        out_valid_q;
  sdr_out_t    out_q, out_d;
  logic        hit;
  logic [7:0]  hit_value;
  logic        do_write;

  assign pop_o       = head_valid_i && (head_i.is_write || !out_valid_q || out_ready_i);
  assign do_write    = pop_o && head_i.is_write;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Parallel compare over all slots, lowest slot wins
  always_comb begin
    hit       = 1'b0;
    hit_value = '0;
    for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
      if (slot_valid_q[s] && slot_id_q[s] == head_i.id && slot_type_q[s] == head_i.kind) begin
        hit       = 1'b1;
        hit_value = slot_value_q[s];
      end
    end
  end

  // Build the result word
  always_comb begin
    out_d.out_word     = head_i.word;
    out_d.was_replaced = 1'b0;
    out_d.bad_length   = head_i.bad;
    if (head_i.lookup && hit) begin
      out_d.out_word     = {24'd0, hit_value};
      out_d.was_replaced = 1'b1;
    end
  end

  // Slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TABLE_SLOTS; s++) begin
        slot_valid_q[s] <= 1'b0;
      end
    end else if (do_write) begin
      for (int s = 0; s < TABLE_SLOTS; s++) begin
        if (32'(head_i.idx) == 32'(s)) begin
          slot_valid_q[s] <= head_i.enable;
        end
      end
    end
  end

  // Slot contents, stored on every write
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      for (int s = 0; s < TABLE_SLOTS; s++) begin
        if (32'(head_i.idx) == 32'(s)) begin
          slot_id_q[s]    <= head_i.id;
          slot_type_q[s]  <= head_i.kind;
          slot_value_q[s] <= head_i.value;
        end
      end
    end
  end

  // Output register: drop on transfer, load on word pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && !head_i.is_write) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !head_i.is_write) begin
      out_q <= out_d;
    end
  end

  `SDR_ASSERT_NXT(a_word_loads, pop_o && !head_i.is_write, out_valid_q, "word pop gave no result")
  `SDR_ASSERT_NXT(a_write_silent, do_write && !out_valid_q, !out_valid_q, "table write gave a result")
  `SDR_ASSERT_NXT(a_replace_needs_lookup, pop_o && !head_i.is_write && !head_i.lookup,
                  !out_q.was_replaced, "word rewritten without lookup")

endmodule

`default_nettype wire

// File: design/spirv_decoration_remapper_unit.sv
// Channel | Dir | Handshake                | Payload
// in      | in  | in_valid_i / in_ready_o  | in_req_i  (sdr_in_t)
// out     | out | out_valid_o / out_ready_i | out_rsp_o (sdr_out_t)
//
// One item per cycle sustained while out_ready_i is high; the parser, a four-entry
// queue and the rewrite stage with its output register each take a transfer every cycle.
// A module word's result is registered first in its queue entry, then in the output
// register, before it turns valid on out_valid_o.
// Table writes give no result.
// Reset (rst_ni low, asynchronous) clears parser state, queue, slot valid bits
// and the output valid flag.
// A stalled output fills the queue, after which in_ready_o drops.
`default_nettype none

module spirv_decoration_remapper_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire sdr_pkg::sdr_in_t  in_req_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      sdr_pkg::sdr_out_t out_rsp_o
);
  import sdr_pkg::*;

  logic       push;
  logic       push_ready;
  sdr_entry_t push_entry;
  logic       head_valid;
  sdr_entry_t head;
  logic       pop;

  sdr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  sdr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  sdr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

`default_nettype wire
